// ===== hw/rtl/ettp_pkg.sv =====
// shared types and constants of the entity text tokenizer
`timescale 1ns / 1ps
`default_nettype none

package ettp_pkg;

    // most results that one request can cause
    localparam int RES_DEPTH = 4;
    localparam logic [2:0] RES_MAX = 3'd4;

    // characters that steer the lexer
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // lexer modes
    typedef enum logic [2:0] {
        LM_BETWEEN = 3'd0,
        LM_SLASH   = 3'd1,
        LM_COMMENT = 3'd2,
        LM_BARE    = 3'd3,
        LM_QUOTED  = 3'd4,
        LM_ESCAPE  = 3'd5
    } t_lex_mode;

    // position in the { key value ... } grammar
    typedef enum logic [1:0] {
        GP_OPEN  = 2'd0,
        GP_KEY   = 2'd1,
        GP_VALUE = 2'd2
    } t_gpos;

    // result kinds
    typedef enum logic [2:0] {
        K_KEY_BYTE = 3'd0,
        K_KEY_END  = 3'd1,
        K_VAL_BYTE = 3'd2,
        K_VAL_END  = 3'd3,
        K_OPEN     = 3'd4,
        K_CLOSE    = 3'd5,
        K_DONE     = 3'd6,
        K_ERROR    = 3'd7
    } t_kind;

    // parser state kept between requests
    typedef struct packed {
        t_lex_mode   mode;
        t_gpos       gpos;
        logic [7:0]  held_byte;
        logic        held_valid;
        logic [1:0]  qlen;
        logic        halted;
    } t_lex_state;

    localparam t_lex_state LEX_RESET = '{
        mode:       LM_BETWEEN,
        gpos:       GP_OPEN,
        held_byte:  8'h00,
        held_valid: 1'b0,
        qlen:       2'd0,
        halted:     1'b0
    };

    // all results caused by one request
    typedef struct packed {
        logic [RES_DEPTH-1:0][2:0] kind;
        logic [RES_DEPTH-1:0][7:0] data;
        logic [2:0]                cnt;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hw/rtl/ettp_step.sv =====
// parser state register and the single-pass step logic for one text byte
`timescale 1ns / 1ps
`default_nettype none

module ettp_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_has_byte,
    input  wire logic              i_end_of_data,
    output ettp_pkg::t_bundle      o_bundle
);

    typedef struct packed {
        ettp_pkg::t_lex_state st;
        ettp_pkg::t_bundle    res;
    } t_work;

    ettp_pkg::t_lex_state r_state;
    ettp_pkg::t_lex_state n_state;
    t_work                w_work;

    // append a result, ignoring the halt flag
    function automatic t_work f_put(t_work w, ettp_pkg::t_kind k, logic [7:0] b);
        t_work r;
        r = w;
        if (r.res.cnt < ettp_pkg::RES_MAX) begin
            r.res.kind[r.res.cnt[1:0]] = k;
            r.res.data[r.res.cnt[1:0]] =
                (k == ettp_pkg::K_KEY_BYTE || k == ettp_pkg::K_VAL_BYTE) ? b : 8'h00;
            r.res.cnt = r.res.cnt + 3'd1;
        end
        return r;
    endfunction

    // append a result unless halted
    function automatic t_work f_emit(t_work w, ettp_pkg::t_kind k, logic [7:0] b);
        t_work r;
        r = w;
        if (!r.st.halted) begin
            r = f_put(r, k, b);
        end
        return r;
    endfunction

    function automatic logic f_is_space(logic [7:0] b);
        return (b == ettp_pkg::CH_SPACE) || (b >= ettp_pkg::CH_TAB && b <= ettp_pkg::CH_CR);
    endfunction

    function automatic logic f_is_brace(logic [7:0] b);
        return (b == ettp_pkg::CH_LBRACE) || (b == ettp_pkg::CH_RBRACE);
    endfunction

    // brace token against the grammar
    function automatic t_work f_brace(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        unique case (r.st.gpos)
            ettp_pkg::GP_OPEN: begin
                if (b == ettp_pkg::CH_LBRACE) begin
                    r = f_emit(r, ettp_pkg::K_OPEN, 8'h00);
                    r.st.gpos = ettp_pkg::GP_KEY;
                end else begin
                    r.st.halted = 1'b1;
                end
            end
            ettp_pkg::GP_KEY: begin
                if (b == ettp_pkg::CH_RBRACE) begin
                    r = f_emit(r, ettp_pkg::K_CLOSE, 8'h00);
                    r.st.gpos = ettp_pkg::GP_OPEN;
                end else begin
                    // open brace where a key belongs is a one-byte key
                    r = f_emit(r, ettp_pkg::K_KEY_BYTE, b);
                    r = f_emit(r, ettp_pkg::K_KEY_END, 8'h00);
                    r.st.gpos = ettp_pkg::GP_VALUE;
                end
            end
            default: begin
                r.st.halted = 1'b1;
            end
        endcase
        return r;
    endfunction

    // one byte of a bare token
    function automatic t_work f_bare_byte(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        unique case (r.st.gpos)
            ettp_pkg::GP_KEY:   r = f_emit(r, ettp_pkg::K_KEY_BYTE, b);
            ettp_pkg::GP_VALUE: r = f_emit(r, ettp_pkg::K_VAL_BYTE, b);
            default:            r.st.halted = 1'b1;
        endcase
        return r;
    endfunction

    // end of a key or value token
    function automatic t_work f_token_end(t_work w);
        t_work r;
        r = w;
        unique case (r.st.gpos)
            ettp_pkg::GP_KEY: begin
                r = f_emit(r, ettp_pkg::K_KEY_END, 8'h00);
                r.st.gpos = ettp_pkg::GP_VALUE;
            end
            ettp_pkg::GP_VALUE: begin
                r = f_emit(r, ettp_pkg::K_VAL_END, 8'h00);
                r.st.gpos = ettp_pkg::GP_KEY;
            end
            default: begin
                r.st.halted = 1'b1;
            end
        endcase
        return r;
    endfunction

    // next byte inside a bare token
    function automatic t_work f_bare_continue(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        if (f_is_space(b)) begin
            r = f_token_end(r);
            r.st.mode = ettp_pkg::LM_BETWEEN;
        end else if (f_is_brace(b)) begin
            r = f_token_end(r);
            r.st.mode = ettp_pkg::LM_BETWEEN;
            r = f_brace(r, b);
        end else begin
            r = f_bare_byte(r, b);
        end
        return r;
    endfunction

    // content byte of a quoted token; the first one is held back
    function automatic t_work f_quoted_push(t_work w, logic [7:0] c);
        t_work           r;
        ettp_pkg::t_kind k;
        r = w;
        k = (r.st.gpos == ettp_pkg::GP_KEY) ? ettp_pkg::K_KEY_BYTE : ettp_pkg::K_VAL_BYTE;
        if (r.st.qlen == 2'd0) begin
            r.st.held_byte  = c;
            r.st.held_valid = 1'b1;
            r.st.qlen       = 2'd1;
        end else begin
            if (r.st.qlen == 2'd1) begin
                if (r.st.gpos != ettp_pkg::GP_OPEN && r.st.held_valid) begin
                    r = f_emit(r, k, r.st.held_byte);
                end
                r.st.held_valid = 1'b0;
                r.st.qlen       = 2'd2;
            end
            if (r.st.gpos != ettp_pkg::GP_OPEN) begin
                r = f_emit(r, k, c);
            end
        end
        return r;
    endfunction

    // closing quote
    function automatic t_work f_quoted_close(t_work w);
        t_work           r;
        ettp_pkg::t_kind k;
        r = w;
        k = (r.st.gpos == ettp_pkg::GP_KEY) ? ettp_pkg::K_KEY_BYTE : ettp_pkg::K_VAL_BYTE;
        if (r.st.qlen == 2'd1 && r.st.held_valid && f_is_brace(r.st.held_byte)) begin
            // quoted single brace acts as a brace
            r = f_brace(r, r.st.held_byte);
        end else if (r.st.gpos == ettp_pkg::GP_OPEN) begin
            r.st.halted = 1'b1;
        end else begin
            if (r.st.qlen == 2'd1 && r.st.held_valid) begin
                r = f_emit(r, k, r.st.held_byte);
            end
            r = f_token_end(r);
        end
        r.st.qlen       = 2'd0;
        r.st.held_valid = 1'b0;
        r.st.held_byte  = 8'h00;
        r.st.mode       = ettp_pkg::LM_BETWEEN;
        return r;
    endfunction

    // byte at a token start
    function automatic t_work f_between(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        if (f_is_space(b)) begin
            r.st.mode = ettp_pkg::LM_BETWEEN;
        end else if (b == ettp_pkg::CH_SLASH) begin
            r.st.mode = ettp_pkg::LM_SLASH;
        end else if (f_is_brace(b)) begin
            r = f_brace(r, b);
        end else if (b == ettp_pkg::CH_QUOTE) begin
            r.st.mode       = ettp_pkg::LM_QUOTED;
            r.st.qlen       = 2'd0;
            r.st.held_valid = 1'b0;
            r.st.held_byte  = 8'h00;
        end else begin
            r.st.mode = ettp_pkg::LM_BARE;
            r = f_bare_byte(r, b);
        end
        return r;
    endfunction

    // one text byte by lexer mode
    function automatic t_work f_take(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        unique case (r.st.mode)
            ettp_pkg::LM_SLASH: begin
                if (b == ettp_pkg::CH_SLASH) begin
                    r.st.mode = ettp_pkg::LM_COMMENT;
                end else begin
                    // lone slash starts a bare token
                    r.st.mode = ettp_pkg::LM_BARE;
                    r = f_bare_byte(r, ettp_pkg::CH_SLASH);
                    r = f_bare_continue(r, b);
                end
            end
            ettp_pkg::LM_COMMENT: begin
                if (b == ettp_pkg::CH_NEWLINE) begin
                    r.st.mode = ettp_pkg::LM_BETWEEN;
                end
            end
            ettp_pkg::LM_BARE: begin
                r = f_bare_continue(r, b);
            end
            ettp_pkg::LM_QUOTED: begin
                if (b == ettp_pkg::CH_QUOTE) begin
                    r = f_quoted_close(r);
                end else if (b == ettp_pkg::CH_BSLASH) begin
                    r.st.mode = ettp_pkg::LM_ESCAPE;
                end else begin
                    r = f_quoted_push(r, b);
                end
            end
            ettp_pkg::LM_ESCAPE: begin
                // only quote and backslash escapes collapse
                if (b != ettp_pkg::CH_QUOTE && b != ettp_pkg::CH_BSLASH) begin
                    r = f_quoted_push(r, ettp_pkg::CH_BSLASH);
                end
                r = f_quoted_push(r, b);
                r.st.mode = ettp_pkg::LM_QUOTED;
            end
            default: begin
                r.st.mode = ettp_pkg::LM_BETWEEN;
                r = f_between(r, b);
            end
        endcase
        return r;
    endfunction

    // end of text: flush, report, return to reset state
    function automatic t_work f_finish(t_work w);
        t_work r;
        r = w;
        if (!r.st.halted) begin
            if (r.st.mode == ettp_pkg::LM_BARE) begin
                r = f_token_end(r);
            end else if (r.st.mode == ettp_pkg::LM_SLASH) begin
                r = f_bare_byte(r, ettp_pkg::CH_SLASH);
                r = f_token_end(r);
            end else if (r.st.mode == ettp_pkg::LM_QUOTED ||
                         r.st.mode == ettp_pkg::LM_ESCAPE) begin
                if (r.st.gpos != ettp_pkg::GP_OPEN) begin
                    r.st.halted = 1'b1;
                end
            end
        end
        if (r.st.halted || r.st.gpos != ettp_pkg::GP_OPEN) begin
            r = f_put(r, ettp_pkg::K_ERROR, 8'h00);
        end else begin
            r = f_put(r, ettp_pkg::K_DONE, 8'h00);
        end
        r.st = ettp_pkg::LEX_RESET;
        return r;
    endfunction

    // work out the whole request in one pass
    always_comb begin
        w_work.st  = r_state;
        w_work.res = '0;
        if (i_has_byte && !r_state.halted) begin
            w_work = f_take(w_work, i_data_byte);
        end
        if (i_end_of_data) begin
            w_work = f_finish(w_work);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (i_load) begin
            n_state = w_work.st;
        end
    end

    // results of this request
    always_comb begin
        o_bundle = w_work.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ettp_pkg::LEX_RESET;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ettp_queue.sv =====
// result register that hands out the results of one request one per cycle while downstream does not stall
`timescale 1ns / 1ps
`default_nettype none

module ettp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_load,
    input  wire ettp_pkg::t_bundle i_bundle,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_of_run
);

    ettp_pkg::t_bundle r_bundle;
    ettp_pkg::t_bundle n_bundle;
    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic              r_valid;
    logic              n_valid;
    logic              w_last;
    logic              w_fire;
    logic              w_free;

    // drain status
    assign w_last = ({1'b0, r_idx} + 3'd1) == r_bundle.cnt;
    assign w_fire = r_valid && !i_stall;
    assign w_free = !r_valid || (w_fire && w_last);

    assign o_stall = !w_free;
    assign o_load  = i_valid && w_free;

    // next register values
    always_comb begin
        n_bundle = r_bundle;
        n_idx    = r_idx;
        n_valid  = r_valid;
        if (o_load) begin
            n_bundle = i_bundle;
            n_idx    = 2'd0;
            n_valid  = (i_bundle.cnt != 3'd0);
        end else if (w_fire) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // current result
    always_comb begin
        o_valid       = r_valid;
        o_kind        = r_bundle.kind[r_idx];
        o_out_byte    = r_bundle.data[r_idx];
        o_last_of_run = w_last;
    end

    always_ff @(posedge i_clk) begin
        r_bundle <= n_bundle;
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/entity_text_tokenizer_parser.sv =====
// top level of the entity text tokenizer and structure checker
// the first result of a request shows on the output in the cycle after it is accepted
// one request per cycle while each request yields at most one result and downstream does not stall;
//   a request with n results (up to four) holds the result register until its last result is taken
// the step logic and the four-entry result register set the rate
// reset: synchronous, active low; clears the parser state and empties the result register
`timescale 1ns / 1ps
`default_nettype none

module entity_text_tokenizer_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);

    ettp_pkg::t_bundle w_bundle;
    logic              w_load;

    // parser step
    ettp_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_end_of_data (i_end_of_data),
        .o_bundle      (w_bundle)
    );

    // result register and drain
    ettp_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .o_load        (w_load),
        .i_bundle      (w_bundle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // upstream is held back only while results wait
    a_stall_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no pending result");

    // done or error always closes a run
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == ettp_pkg::K_DONE || o_kind == ettp_pkg::K_ERROR)
        |-> o_last_of_run)
        else $error("end of data result not last of its run");

    // non-byte results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != ettp_pkg::K_KEY_BYTE && o_kind != ettp_pkg::K_VAL_BYTE
        |-> o_out_byte == 8'h00)
        else $error("nonzero byte on a non-byte result");

    // a request with several results keeps upstream stalled until the last one
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_stall)
        else $error("request accepted before the run finished");

endmodule

`default_nettype wire
